/* rtl/u16u8_pkg.sv */
`default_nettype none

package u16u8_pkg;

    localparam int unsigned LenWidth   = 21;
    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

    localparam logic [LenWidth-1:0] MaxBytesReset = 21'h100000;

    localparam logic [15:0] UnitPacket   = 16'h001A;
    localparam logic [5:0]  SurrHiTag    = 6'b110110;
    localparam logic [5:0]  SurrLoTag    = 6'b110111;
    localparam logic [LenWidth-1:0] SuppBase = 21'h010000;
    localparam logic [7:0]  MinPacketLen = 8'd4;
    localparam logic [7:0]  PacketHead   = 8'd3;

    localparam logic [7:0] Lead2 = 8'hC0;
    localparam logic [7:0] Lead3 = 8'hE0;
    localparam logic [7:0] Lead4 = 8'hF0;
    localparam logic [7:0] Cont  = 8'h80;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_UNIT_HI = 3'd1,
        PH_UNIT_LO = 3'd2,
        PH_PKT_LEN = 3'd3,
        PH_SKIP    = 3'd4,
        PH_PAIR_HI = 3'd5,
        PH_PAIR_LO = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        KIND_TEXT = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ERR_NONE        = 4'd0,
        ERR_START_SHORT = 4'd1,
        ERR_TRUNC_PKT   = 4'd2,
        ERR_BAD_PKT     = 4'd3,
        ERR_TRUNC_PAIR  = 4'd4,
        ERR_BAD_PAIR    = 4'd5,
        ERR_LONE_LOW    = 4'd6,
        ERR_TOO_LONG    = 4'd7,
        ERR_UNTERM      = 4'd8
    } err_t;

    // one request from the decoder: a code point, a clean end or an error
    typedef struct packed {
        kind_t               kind;
        logic [LenWidth-1:0] value;   // code point or message length
        logic [1:0]          last;    // UTF-8 width minus one
        err_t                code;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

/* rtl/u16u8_front.sv */
`default_nettype none

module u16u8_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [u16u8_pkg::LenWidth-1:0] cfg_data,
    input  wire logic                          accept,
    input  wire logic [7:0]                    data_byte,
    input  wire logic                          first_of_message,
    input  wire logic                          end_of_area,
    output logic                               job_push,
    output u16u8_pkg::job_t                    job
);
    import u16u8_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [7:0]          high_byte_reg, high_byte_next;
    logic [9:0]          pend_reg, pend_next;
    logic [7:0]          skip_reg, skip_next;
    logic [LenWidth-1:0] written_reg, written_next;
    logic [LenWidth-1:0] max_reg;

    phase_t              eff_phase;
    logic [LenWidth-1:0] eff_written;
    logic [15:0]         unit;
    logic                is_zero, is_pkt, is_hi, is_lo;
    logic                pkt_bad;
    logic [7:0]          skip_dec;
    logic                skip_last;
    logic [LenWidth-1:0] pair_point, point;
    logic [1:0]          width_last;
    logic [2:0]          width;
    logic [LenWidth:0]   total;
    logic                too_long;

    // a message start restarts the decoder on this very byte
    assign eff_phase   = first_of_message ? PH_UNIT_HI : phase_reg;
    assign eff_written = first_of_message ? '0 : written_reg;

    assign unit       = {high_byte_reg, data_byte};
    assign is_zero    = (unit == 16'h0000);
    assign is_pkt     = (unit == UnitPacket);
    assign is_hi      = (unit[15:10] == SurrHiTag);
    assign is_lo      = (unit[15:10] == SurrLoTag);
    assign pkt_bad    = (data_byte < MinPacketLen);
    assign skip_dec   = skip_reg - 8'd1;
    assign skip_last  = (skip_dec == 8'd0);
    assign pair_point = SuppBase + {1'b0, pend_reg, unit[9:0]};
    assign point      = (eff_phase == PH_PAIR_LO) ? pair_point
                                                  : {{(LenWidth-16){1'b0}}, unit};

    always_comb
    begin
        if (point < 21'h80)
            width_last = 2'd0;
        else if (point < 21'h800)
            width_last = 2'd1;
        else if (point < 21'h10000)
            width_last = 2'd2;
        else
            width_last = 2'd3;
    end

    assign width    = {1'b0, width_last} + 3'd1;
    assign total    = {1'b0, eff_written} + {{(LenWidth-2){1'b0}}, width};
    assign too_long = (total > {1'b0, max_reg});

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            case (eff_phase)
                PH_IDLE:    phase_next = PH_IDLE;
                PH_UNIT_HI: phase_next = end_of_area ? PH_IDLE : PH_UNIT_LO;
                PH_UNIT_LO:
                begin
                    if (is_zero || is_lo)
                        phase_next = PH_IDLE;
                    else if (is_pkt)
                        phase_next = end_of_area ? PH_IDLE : PH_PKT_LEN;
                    else if (is_hi)
                        phase_next = end_of_area ? PH_IDLE : PH_PAIR_HI;
                    else
                        phase_next = (too_long || end_of_area) ? PH_IDLE : PH_UNIT_HI;
                end
                PH_PKT_LEN: phase_next = (pkt_bad || end_of_area) ? PH_IDLE : PH_SKIP;
                PH_SKIP:
                begin
                    if (end_of_area)
                        phase_next = PH_IDLE;
                    else
                        phase_next = skip_last ? PH_UNIT_HI : PH_SKIP;
                end
                PH_PAIR_HI: phase_next = end_of_area ? PH_IDLE : PH_PAIR_LO;
                PH_PAIR_LO:
                begin
                    if (!is_lo || too_long || end_of_area)
                        phase_next = PH_IDLE;
                    else
                        phase_next = PH_UNIT_HI;
                end
                default:    phase_next = PH_IDLE;
            endcase
        end
    end

    // requests and data registers
    always_comb
    begin
        job_push       = 1'b0;
        job.kind       = KIND_ERR;
        job.value      = '0;
        job.last       = 2'd0;
        job.code       = ERR_NONE;
        high_byte_next = high_byte_reg;
        pend_next      = pend_reg;
        skip_next      = skip_reg;
        written_next   = (accept && first_of_message) ? '0 : written_reg;
        if (accept)
        begin
            case (eff_phase)
                PH_IDLE: ;
                PH_UNIT_HI:
                begin
                    if (end_of_area)
                    begin
                        job_push = 1'b1;
                        job.code = first_of_message ? ERR_START_SHORT : ERR_UNTERM;
                    end
                    else
                        high_byte_next = data_byte;
                end
                PH_PKT_LEN:
                begin
                    if (pkt_bad || end_of_area)
                    begin
                        job_push = 1'b1;
                        job.code = ERR_BAD_PKT;
                    end
                    else
                        skip_next = data_byte - PacketHead;
                end
                PH_SKIP:
                begin
                    skip_next = skip_dec;
                    if (end_of_area)
                    begin
                        job_push = 1'b1;
                        job.code = skip_last ? ERR_UNTERM : ERR_BAD_PKT;
                    end
                end
                PH_PAIR_HI:
                begin
                    if (end_of_area)
                    begin
                        job_push = 1'b1;
                        job.code = ERR_TRUNC_PAIR;
                    end
                    else
                        high_byte_next = data_byte;
                end
                PH_UNIT_LO, PH_PAIR_LO:
                begin
                    if (eff_phase == PH_UNIT_LO && is_zero)
                    begin
                        job_push  = 1'b1;
                        job.kind  = KIND_END;
                        job.value = eff_written;
                    end
                    else if (eff_phase == PH_UNIT_LO && is_pkt)
                    begin
                        if (end_of_area)
                        begin
                            job_push = 1'b1;
                            job.code = ERR_TRUNC_PKT;
                        end
                    end
                    else if (eff_phase == PH_UNIT_LO && is_hi)
                    begin
                        if (end_of_area)
                        begin
                            job_push = 1'b1;
                            job.code = ERR_TRUNC_PAIR;
                        end
                        else
                            pend_next = unit[9:0];
                    end
                    else if (eff_phase == PH_UNIT_LO && is_lo)
                    begin
                        job_push = 1'b1;
                        job.code = ERR_LONE_LOW;
                    end
                    else if (eff_phase == PH_PAIR_LO && !is_lo)
                    begin
                        job_push = 1'b1;
                        job.code = ERR_BAD_PAIR;
                    end
                    else if (too_long)
                    begin
                        job_push = 1'b1;
                        job.code = ERR_TOO_LONG;
                    end
                    else if (end_of_area)
                    begin
                        job_push = 1'b1;
                        job.code = ERR_UNTERM;
                    end
                    else
                    begin
                        job_push     = 1'b1;
                        job.kind     = KIND_TEXT;
                        job.value    = point;
                        job.last     = width_last;
                        written_next = total[LenWidth-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            high_byte_reg <= '0;
            pend_reg      <= '0;
            skip_reg      <= '0;
            written_reg   <= '0;
            max_reg       <= MaxBytesReset;
        end
        else
        begin
            phase_reg     <= phase_next;
            high_byte_reg <= high_byte_next;
            pend_reg      <= pend_next;
            skip_reg      <= skip_next;
            written_reg   <= written_next;
            if (cfg_write)
                max_reg <= cfg_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/u16u8_queue.sv */
`default_nettype none

module u16u8_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire u16u8_pkg::job_t       push_job,
    input  wire logic                  pop,
    output u16u8_pkg::job_t            head_job,
    output u16u8_pkg::q_status_t       status
);
    import u16u8_pkg::*;

    job_t                 slot_reg [QueueDepth];
    logic [QueuePtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QueuePtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QueuePtrW:0]   count_reg, count_next;
    logic                 do_push, do_pop;

    assign status.full  = (count_reg == (QueuePtrW+1)'(QueueDepth));
    assign status.empty = (count_reg == '0);
    assign head_job     = slot_reg[rd_ptr_reg];

    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/u16u8_back.sv */
`default_nettype none

module u16u8_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire u16u8_pkg::job_t               head_job,
    input  wire u16u8_pkg::q_status_t          q_status,
    output logic                               q_pop,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [7:0]                         utf8_byte,
    output logic [1:0]                         kind,
    output logic [3:0]                         error_code,
    output logic [u16u8_pkg::LenWidth-1:0]      message_length,
    output logic                               last_of_run
);
    import u16u8_pkg::*;

    logic       cur_valid_reg, cur_valid_next;
    job_t       cur_reg, cur_next;
    logic [1:0] idx_reg, idx_next;
    logic       is_last, done, take;
    logic [LenWidth-1:0] pt;

    assign empty   = !cur_valid_reg;
    assign is_last = (idx_reg == cur_reg.last);
    assign done    = pop && cur_valid_reg && is_last;
    assign take    = (!cur_valid_reg || done) && !q_status.empty;
    assign q_pop   = take;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        if (take)
        begin
            cur_valid_next = 1'b1;
            cur_next       = head_job;
            idx_next       = 2'd0;
        end
        else if (done)
            cur_valid_next = 1'b0;
        else if (pop && cur_valid_reg)
            idx_next = idx_reg + 2'd1;
    end

    // pick the UTF-8 byte for this position of the code point
    assign pt = cur_reg.value;
    always_comb
    begin
        utf8_byte = 8'h00;
        if (cur_reg.kind == KIND_TEXT)
        begin
            case ({cur_reg.last, idx_reg})
                4'b00_00: utf8_byte = pt[7:0];
                4'b01_00: utf8_byte = Lead2 | {3'b000, pt[10:6]};
                4'b01_01: utf8_byte = Cont | {2'b00, pt[5:0]};
                4'b10_00: utf8_byte = Lead3 | {4'b0000, pt[15:12]};
                4'b10_01: utf8_byte = Cont | {2'b00, pt[11:6]};
                4'b10_10: utf8_byte = Cont | {2'b00, pt[5:0]};
                4'b11_00: utf8_byte = Lead4 | {5'b00000, pt[20:18]};
                4'b11_01: utf8_byte = Cont | {2'b00, pt[17:12]};
                4'b11_10: utf8_byte = Cont | {2'b00, pt[11:6]};
                4'b11_11: utf8_byte = Cont | {2'b00, pt[5:0]};
                default:  utf8_byte = 8'h00;
            endcase
        end
    end

    assign kind           = cur_reg.kind;
    assign error_code     = (cur_reg.kind == KIND_ERR) ? cur_reg.code : ERR_NONE;
    assign message_length = (cur_reg.kind == KIND_END) ? cur_reg.value : '0;
    assign last_of_run    = is_last;

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/utf16be_to_utf8_escape_skip.sv */
`default_nettype none

// channel   handshake          payload
// input     push / full        data_byte, first_of_message, end_of_area
// result    empty / pop        utf8_byte, kind, error_code, message_length, last_of_run
// config    cfg_write          cfg_data (max_message_bytes)
//
// One input byte is taken per cycle while the request queue (4 deep) has room.
// The decoder turns each byte into at most one request in the same cycle.
// The emitter gives one result per pop while a result is ready; a code point yields 1 to 4 UTF-8 bytes.
// Reset (rst_n low, async) empties the queue and returns the decoder to idle.
// full rises only when the queue fills behind a stalled or slow result side.

module utf16be_to_utf8_escape_skip (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [u16u8_pkg::LenWidth-1:0] cfg_data,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [7:0]                    data_byte,
    input  wire logic                          first_of_message,
    input  wire logic                          end_of_area,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [7:0]                         utf8_byte,
    output logic [1:0]                         kind,
    output logic [3:0]                         error_code,
    output logic [u16u8_pkg::LenWidth-1:0]      message_length,
    output logic                               last_of_run
);
    import u16u8_pkg::*;

    logic      accept;
    logic      job_push;
    job_t      job;
    job_t      head_job;
    q_status_t q_status;
    logic      q_pop;

    assign full   = q_status.full;
    assign accept = push && !q_status.full;

    u16u8_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_data         (cfg_data),
        .accept           (accept),
        .data_byte        (data_byte),
        .first_of_message (first_of_message),
        .end_of_area      (end_of_area),
        .job_push         (job_push),
        .job              (job)
    );

    u16u8_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (job),
        .pop      (q_pop),
        .head_job (head_job),
        .status   (q_status)
    );

    u16u8_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_job       (head_job),
        .q_status       (q_status),
        .q_pop          (q_pop),
        .empty          (empty),
        .pop            (pop),
        .utf8_byte      (utf8_byte),
        .kind           (kind),
        .error_code     (error_code),
        .message_length (message_length),
        .last_of_run    (last_of_run)
    );

endmodule

`default_nettype wire
